FILE: src/rp2d_pkg.sv
// ----------------------------------------------------------------------------
// rp2d_pkg: shared types and constants of the planar rigid-pose unit
// Holds the operation codes, the CORDIC arctangent table, the gain constant
// and the structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package rp2d_pkg;

  // Number of CORDIC rotations requested; the table covers at most ATAN_LEN.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  // Rotator widths: x/y in Q2.30 with headroom, z as a 2^32-per-turn phase.
  localparam int CW = 34;
  localparam int ZW = 33;

  localparam logic signed [CW-1:0] GAIN_Q30  = CW'(652032874);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
  localparam logic signed [15:0]   QUARTER   = 16'sd16384;

  // Arctangent of 2^-i in phase units (2^32 is one turn).
  localparam logic [29:0] ATAN_TURN [ATAN_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef enum logic [1:0] {
    MODE_COMPOSE = 2'd0,
    MODE_APPLY   = 2'd1,
    MODE_INVERSE = 2'd2
  } mode_t;

  // Operands that ride alongside the rotator until the multipliers.
  typedef struct packed {
    logic               inv;
    logic signed [15:0] ang;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } carry_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    carry_t               carry;
  } cordic_t;

endpackage

FILE: src/rp2d_cordic.sv
// ----------------------------------------------------------------------------
// rp2d_cordic: pipelined CORDIC rotator
// One micro-rotation per register stage. Each stage holds its item until the
// next stage can take it, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module rp2d_cordic
  import rp2d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cordic_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cordic_t out_data
);

  logic [CORDIC_RUN-1:0] v;
  logic [CORDIC_RUN:0]   rdy;
  cordic_t               st [CORDIC_RUN];

  assign rdy[CORDIC_RUN] = out_ready;

  genvar i;
  generate
    for (i = 0; i < CORDIC_RUN; i++) begin : g_stage
      cordic_t src;
      logic    src_v;
      cordic_t nxt;

      if (i == 0) begin : g_first
        assign src   = in_data;
        assign src_v = in_valid;
      end else begin : g_rest
        assign src   = st[i-1];
        assign src_v = v[i-1];
      end

      assign rdy[i] = ~v[i] | rdy[i+1];

      always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] da;
        dx = src.x >>> i;
        dy = src.y >>> i;
        da = $signed({3'b000, ATAN_TURN[i]});
        nxt = src;
        if (src.z >= 0) begin
          nxt.x = src.x - dy;
          nxt.y = src.y + dx;
          nxt.z = src.z - da;
        end else begin
          nxt.x = src.x + dy;
          nxt.y = src.y - dx;
          nxt.z = src.z + da;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (rdy[i]) begin
          v[i] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          st[i] <= nxt;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v[CORDIC_RUN-1];
  assign out_data  = st[CORDIC_RUN-1];

endmodule

FILE: src/rigid_pose_2d_transform.sv
// ----------------------------------------------------------------------------
// rigid_pose_2d_transform: planar rigid-pose compose, point transform, inverse
// Top level. Every item goes through a quadrant-fold entry stage, a sine/cosine
// CORDIC pipeline, multiplier, sum and rounding/saturation output stages.
// ----------------------------------------------------------------------------
// How to use it:
//   The input channel (in_valid/in_stall) carries one item: mode, pose A and
//   operand B. An item is taken at a rising edge where in_valid is high and
//   in_stall is low. Results leave on out_valid/out_stall with the same rule.
//   Mode compose returns A*B, mode apply returns A applied to the point B
//   with a zero heading, mode inverse returns the inverse of A. The unused
//   mode code returns an all-zero result.
//   Throughput is one item per clock cycle while the output is not stalled.
//   The stages in order: one for the quadrant fold, one per CORDIC rotation,
//   then multiply, sum and round/saturate. The depth is set by the CORDIC
//   rotation chain.
//   Every stage keeps its own valid bit and moves on whenever the stage after
//   it is empty or moving, so a stall on the output fills the empty slots
//   first; in_stall only rises once the whole pipeline is full. No item is
//   dropped or repeated under stall.
//   A synchronous reset clears all valid bits; items in flight are discarded
//   and the block takes a new item in the first cycle after reset.
// ----------------------------------------------------------------------------
module rigid_pose_2d_transform
  import rp2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] angle_a,
  input  logic signed [31:0] x_a,
  input  logic signed [31:0] y_a,
  input  logic signed [15:0] angle_b,
  input  logic signed [31:0] x_b,
  input  logic signed [31:0] y_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] angle_out,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic               overflow
);

  localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
  localparam logic signed [36:0] SAT_MAX    = 37'sd2147483647;
  localparam logic signed [36:0] SAT_MIN    = -37'sd2147483648;

  // Handshake chain, from the output backwards.
  logic o_rdy;
  logic a_rdy;
  logic m_rdy;
  logic s0_rdy;
  logic c_in_rdy;

  // Entry stage: quadrant fold and operand selection.
  logic    s0_v;
  cordic_t s0;
  cordic_t s0_next;

  // CORDIC output.
  logic    c_v;
  cordic_t c_d;

  // Multiplier stage.
  logic               m_v;
  logic signed [63:0] m_cp;
  logic signed [63:0] m_sq;
  logic signed [63:0] m_sp;
  logic signed [63:0] m_cq;
  carry_t             m_carry;

  // Sum stage: exact rotated sums plus the rounding half.
  logic               a_v;
  logic signed [65:0] a_x;
  logic signed [65:0] a_y;
  logic signed [15:0] a_ang;
  logic signed [31:0] a_tx;
  logic signed [31:0] a_ty;
  logic signed [65:0] a_x_next;
  logic signed [65:0] a_y_next;

  // Output stage inputs.
  logic signed [36:0] x_sum;
  logic signed [36:0] y_sum;
  logic signed [31:0] x_sat;
  logic signed [31:0] y_sat;
  logic               x_ovf;
  logic               y_ovf;

  assign o_rdy    = ~out_valid | ~out_stall;
  assign a_rdy    = ~a_v | o_rdy;
  assign m_rdy    = ~m_v | a_rdy;
  assign s0_rdy   = ~s0_v | c_in_rdy;
  assign in_stall = ~s0_rdy;

  // The start vector is (K, 0); headings beyond a quarter turn are folded by
  // half a turn and the start vector is negated to compensate.
  always_comb begin
    logic signed [ZW-1:0] zi;
    zi = {angle_a[15], angle_a, 16'h0000};
    s0_next.y = '0;
    if (angle_a > QUARTER) begin
      s0_next.x = -GAIN_Q30;
      s0_next.z = zi - HALF_TURN;
    end else if (angle_a < -QUARTER) begin
      s0_next.x = -GAIN_Q30;
      s0_next.z = zi + HALF_TURN;
    end else begin
      s0_next.x = GAIN_Q30;
      s0_next.z = zi;
    end

    // Compose and apply rotate B and translate by A; inverse rotates A
    // backwards with no translation. The unused code zeroes every operand,
    // which yields an all-zero result.
    s0_next.carry = '0;
    unique case (mode)
      MODE_COMPOSE: begin
        s0_next.carry.ang = angle_a + angle_b;
        s0_next.carry.p   = x_b;
        s0_next.carry.q   = y_b;
        s0_next.carry.tx  = x_a;
        s0_next.carry.ty  = y_a;
      end
      MODE_APPLY: begin
        s0_next.carry.p  = x_b;
        s0_next.carry.q  = y_b;
        s0_next.carry.tx = x_a;
        s0_next.carry.ty = y_a;
      end
      MODE_INVERSE: begin
        s0_next.carry.inv = 1'b1;
        s0_next.carry.ang = -angle_a;
        s0_next.carry.p   = x_a;
        s0_next.carry.q   = y_a;
      end
      default: begin
        s0_next.carry = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy) begin
      s0 <= s0_next;
    end
  end

  rp2d_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_v),
    .in_ready  (c_in_rdy),
    .in_data   (s0),
    .out_valid (c_v),
    .out_ready (m_rdy),
    .out_data  (c_d)
  );

  // Four 32 by 32 products of cosine/sine with the selected operand pair.
  // The rotated vector stays within about one in Q2.30, so 32 bits hold it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_rdy) begin
      m_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy) begin
      m_cp    <= 64'($signed(c_d.x[31:0])) * 64'(c_d.carry.p);
      m_sq    <= 64'($signed(c_d.y[31:0])) * 64'(c_d.carry.q);
      m_sp    <= 64'($signed(c_d.y[31:0])) * 64'(c_d.carry.p);
      m_cq    <= 64'($signed(c_d.x[31:0])) * 64'(c_d.carry.q);
      m_carry <= c_d.carry;
    end
  end

  // Compose/apply: x = c*p - s*q, y = s*p + c*q.
  // Inverse: x = -(c*p + s*q), y = s*p - c*q. Half an LSB is added here so
  // that the output stage only has to shift, translate and saturate.
  always_comb begin
    logic signed [65:0] cp;
    logic signed [65:0] sq;
    logic signed [65:0] sp;
    logic signed [65:0] cq;
    cp = 66'(m_cp);
    sq = 66'(m_sq);
    sp = 66'(m_sp);
    cq = 66'(m_cq);
    if (m_carry.inv) begin
      a_x_next = ROUND_HALF - cp - sq;
      a_y_next = ROUND_HALF + sp - cq;
    end else begin
      a_x_next = ROUND_HALF + cp - sq;
      a_y_next = ROUND_HALF + sp + cq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_x   <= a_x_next;
      a_y   <= a_y_next;
      a_ang <= m_carry.ang;
      a_tx  <= m_carry.tx;
      a_ty  <= m_carry.ty;
    end
  end

  // The arithmetic shift floors, which with the added half gives round half
  // up; the translation comes after rounding and the sum is then clamped.
  assign x_sum = 37'($signed(a_x[65:30])) + 37'(a_tx);
  assign y_sum = 37'($signed(a_y[65:30])) + 37'(a_ty);

  always_comb begin
    x_ovf = 1'b1;
    y_ovf = 1'b1;
    priority if (x_sum > SAT_MAX) begin
      x_sat = 32'sh7FFF_FFFF;
    end else if (x_sum < SAT_MIN) begin
      x_sat = 32'sh8000_0000;
    end else begin
      x_sat = x_sum[31:0];
      x_ovf = 1'b0;
    end
    priority if (y_sum > SAT_MAX) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (y_sum < SAT_MIN) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = y_sum[31:0];
      y_ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_rdy) begin
      out_valid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      angle_out <= a_ang;
      x_out     <= x_sat;
      y_out     <= y_sat;
      overflow  <= x_ovf | y_ovf;
    end
  end

  // A flagged overflow must come with at least one coordinate at a rail.
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (x_out == 32'sh7FFF_FFFF || x_out == 32'sh8000_0000 ||
       y_out == 32'sh7FFF_FFFF || y_out == 32'sh8000_0000))
    else $error("overflow flagged without a saturated coordinate");

  // The input is only held off while the entry stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s0_v)
    else $error("input stalled with an empty entry stage");

  // A result can only appear if the sum stage held an item the cycle before.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(a_v))
    else $error("result appeared without a source item");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the planar rigid-pose unit
// Drives compose, point-apply, inverse and unused-mode items through the
// valid/stall input channel and checks every result against a bit-exact
// CORDIC and fixed-point predictor held in a small scoreboard class. It runs
// a directed set first, then random items under several idling and stall
// mixes, including one long output hold that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb;
  import rp2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The mode code that the package leaves unnamed; the block returns zeros.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Rotator constants: the gain compensation in Q2.30 and the arctangent of
  // 2^-i in phase units, where 2^32 is one full turn.
  localparam longint CORDIC_GAIN   = 64'sd652032874;
  localparam longint QUARTER_PHASE = 64'sd1073741824;
  localparam longint HALF_PHASE    = 64'sd2147483648;
  localparam longint ROUND_HALF    = 64'sd536870912;
  localparam int     ATAN_ENTRIES  = 24;
  localparam longint PHASE_ATAN [ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Headings that sit on the wrap point, on and either side of the fold, and around zero.
  localparam logic signed [15:0] EDGE_HEADINGS [9] = '{
    -16'sd32768, 16'sd32767, 16'sd0, 16'sd16384, 16'sd16385,
    -16'sd16384, -16'sd16385, 16'sd1, -16'sd1
  };

  localparam int LATENCY     = CORDIC_STAGES + 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] angle_a;
    logic signed [31:0] x_a;
    logic signed [31:0] y_a;
    logic signed [15:0] angle_b;
    logic signed [31:0] x_b;
    logic signed [31:0] y_b;
  } pose_item_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
  } pose_out_t;

  // Round a Q2.30-scaled product sum to Q16.16, half up.
  function automatic longint round_q30(longint v);
    return (v + ROUND_HALF) >>> 30;
  endfunction

  // Clamp to the int32 range and flag the clamp.
  function automatic longint saturate(longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  class pose_scoreboard;
    pose_out_t pending_poses[$];
    int        errors = 0;

    // Works out the exact result of one item: CORDIC sine and cosine of
    // heading A, then the rotated, rounded and saturated position.
    function pose_out_t rigid_pose_result(pose_item_t it);
      longint x, y, z, dx, dy, xa, ya, xb, yb;
      bit ovf;
      pose_out_t r;
      r = '0;
      ovf = 1'b0;
      z = longint'($signed(it.angle_a)) * 65536;
      x = CORDIC_GAIN;
      y = 0;
      // Fold the phase into the right half-plane and flip the start vector.
      if (z > QUARTER_PHASE) begin
        z -= HALF_PHASE;
        x = -x;
      end else if (z < -QUARTER_PHASE) begin
        z += HALF_PHASE;
        x = -x;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= PHASE_ATAN[5'(i)];
        end else begin
          x += dx;
          y -= dy;
          z += PHASE_ATAN[5'(i)];
        end
      end
      // From here x is the cosine and y the sine, both in Q2.30.
      xa = $signed(it.x_a);
      ya = $signed(it.y_a);
      xb = $signed(it.x_b);
      yb = $signed(it.y_b);
      case (it.mode)
        MODE_COMPOSE, MODE_APPLY: begin
          r.x = 32'(saturate(round_q30(x * xb - y * yb) + xa, ovf));
          r.y = 32'(saturate(round_q30(y * xb + x * yb) + ya, ovf));
          if (it.mode == MODE_COMPOSE)
            r.angle = 16'($signed(it.angle_a) + $signed(it.angle_b));
        end
        MODE_INVERSE: begin
          r.x = 32'(saturate(round_q30(-(x * xa + y * ya)), ovf));
          r.y = 32'(saturate(round_q30(y * xa - x * ya), ovf));
          r.angle = 16'(-longint'($signed(it.angle_a)));
        end
        default: ;
      endcase
      r.ovf = ovf;
      return r;
    endfunction

    function void note_item(pose_item_t it);
      pending_poses.push_back(rigid_pose_result(it));
    endfunction

    function void check_item(pose_out_t got);
      pose_out_t want;
      if (pending_poses.size() == 0) begin
        $error("result with no pending item: angle_out %0d x_out %0d y_out %0d",
               got.angle, got.x, got.y);
        errors++;
        return;
      end
      want = pending_poses.pop_front();
      if (got.angle !== want.angle) begin
        $error("angle_out: expected %0d, got %0d", want.angle, got.angle);
        errors++;
      end
      if (got.x !== want.x) begin
        $error("x_out: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("y_out: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic signed [15:0] angle_a;
  logic signed [31:0] x_a;
  logic signed [31:0] y_a;
  logic signed [15:0] angle_b;
  logic signed [31:0] x_b;
  logic signed [31:0] y_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] angle_out;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic               overflow;

  pose_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls;
  // the main sequence changes them from phase to phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Cycles of unbroken output stall still to come; the receiver counts it.
  int hold_left      = 0;
  int cycle_count    = 0;

  rigid_pose_2d_transform dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .angle_a   (angle_a),
    .x_a       (x_a),
    .y_a       (y_a),
    .angle_b   (angle_b),
    .x_b       (x_b),
    .y_b       (y_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle_out (angle_out),
    .x_out     (x_out),
    .y_out     (y_out),
    .overflow  (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Receiver side. The stall is chosen at the falling edge; a long hold,
  // once requested, takes priority and is counted down here cycle by cycle.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every result taken at a rising edge goes straight to the scoreboard.
  always @(posedge clk) begin
    pose_out_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{angle: angle_out, x: x_out, y: y_out, ovf: overflow};
      sb.check_item(got);
    end
  end

  function automatic pose_item_t make_item(logic [1:0] m,
                                           logic signed [15:0] aa,
                                           logic signed [31:0] xa,
                                           logic signed [31:0] ya,
                                           logic signed [15:0] ab,
                                           logic signed [31:0] xb,
                                           logic signed [31:0] yb);
    pose_item_t it;
    it = '{mode: m, angle_a: aa, x_a: xa, y_a: ya, angle_b: ab, x_b: xb, y_b: yb};
    return it;
  endfunction

  // Headings: mostly uniform, with a fair share at the wrap and fold points.
  function automatic logic signed [15:0] random_heading();
    if ($urandom_range(4) == 0)
      return EDGE_HEADINGS[4'($urandom_range(8))];
    return 16'($urandom);
  endfunction

  // Positions: mostly moderate values that stay clear of saturation, with
  // full-range values and the extremes mixed in to drive the clamp.
  function automatic logic signed [31:0] random_position();
    logic [31:0]        r;
    logic signed [31:0] v;
    r = $urandom;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: v = POS_MAX;
          1: v = POS_MIN;
          2: v = 32'sd0;
          3: v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      1, 2: v = r;
      default: v = 32'($signed(r[24:0]));
    endcase
    return v;
  endfunction

  function automatic pose_item_t random_item();
    logic [1:0] m;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5:          m = MODE_COMPOSE;
      6, 7, 8, 9, 10, 11:        m = MODE_APPLY;
      12, 13, 14, 15, 16, 17, 18: m = MODE_INVERSE;
      default:                   m = MODE_UNUSED;
    endcase
    return make_item(m, random_heading(), random_position(), random_position(),
                     random_heading(), random_position(), random_position());
  endfunction

  // Offers one item from a falling edge and returns at the falling edge
  // after it was taken. in_valid is left high so that a following item can
  // go out back to back; the caller lowers it when nothing follows.
  task automatic send_item(pose_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode     <= it.mode;
    angle_a  <= it.angle_a;
    x_a      <= it.x_a;
    y_a      <= it.y_a;
    angle_b  <= it.angle_b;
    x_b      <= it.x_b;
    y_b      <= it.y_b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 83, 0, 20};
    stall_mix = '{0, 0, 83, 20};

    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    mode      = MODE_COMPOSE;
    angle_a   = '0;
    x_a       = '0;
    y_a       = '0;
    angle_b   = '0;
    x_b       = '0;
    y_b       = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items, sent back to back with a free-running receiver.
    // Identity compose and a quarter turn applied to a unit pose.
    send_item(make_item(MODE_COMPOSE, 16'sd0, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0));
    send_item(make_item(MODE_COMPOSE, 16'sd16384, ONE_Q16, 32'sd0,
                        16'sd0, ONE_Q16, 32'sd0));
    // Heading wrap: just below pi plus one step comes out as -pi, and -pi
    // plus -pi wraps to zero.
    send_item(make_item(MODE_COMPOSE, 16'sd32767, 32'sd100, -32'sd100,
                        16'sd1, 32'sd5, 32'sd7));
    send_item(make_item(MODE_COMPOSE, -16'sd32768, -ONE_Q16, ONE_Q16,
                        -16'sd32768, ONE_Q16, ONE_Q16));
    send_item(make_item(MODE_COMPOSE, 16'sd8192, POS_MAX, POS_MIN,
                        16'sd32767, POS_MIN, POS_MAX));
    send_item(make_item(MODE_COMPOSE, -16'sd1, -32'sd3, -32'sd1,
                        -16'sd32768, -32'sd1, -32'sd1));
    // Point mode: angle_b must have no effect on the result.
    send_item(make_item(MODE_APPLY, 16'sd16384, 32'sd0, 32'sd0,
                        16'sd12345, ONE_Q16, 32'sd0));
    send_item(make_item(MODE_APPLY, -16'sd16384, POS_MAX, POS_MAX,
                        -16'sd32768, POS_MAX, POS_MAX));
    send_item(make_item(MODE_APPLY, 16'sd0, POS_MAX, POS_MIN,
                        16'sd32767, 32'sd1, -32'sd1));
    send_item(make_item(MODE_APPLY, 16'sd32767, POS_MIN, POS_MAX,
                        16'sd1, POS_MIN, POS_MIN));
    send_item(make_item(MODE_APPLY, 16'sd1, 32'sd12, -32'sd12,
                        -16'sd1, 32'sd3, 32'sd4));
    // Inverse of -pi stays -pi; headings on and either side of the fold.
    send_item(make_item(MODE_INVERSE, -16'sd32768, ONE_Q16, -ONE_Q16,
                        16'sd0, 32'sd0, 32'sd0));
    send_item(make_item(MODE_INVERSE, 16'sd16384, ONE_Q16, ONE_Q16,
                        16'sd77, 32'sd9, 32'sd9));
    send_item(make_item(MODE_INVERSE, 16'sd16385, POS_MAX, 32'sd1,
                        16'sd0, 32'sd0, 32'sd0));
    send_item(make_item(MODE_INVERSE, -16'sd16384, -ONE_Q16, 32'sd3,
                        16'sd0, 32'sd0, 32'sd0));
    send_item(make_item(MODE_INVERSE, -16'sd16385, 32'sd1, POS_MIN,
                        16'sd0, 32'sd0, 32'sd0));
    // Negating the most negative position saturates.
    send_item(make_item(MODE_INVERSE, 16'sd0, POS_MIN, POS_MIN,
                        16'sd0, 32'sd0, 32'sd0));
    send_item(make_item(MODE_INVERSE, 16'sd32767, POS_MAX, POS_MAX,
                        -16'sd1, -32'sd1, -32'sd1));
    // The unused mode code gives an all-zero result whatever the operands.
    send_item(make_item(MODE_UNUSED, 16'sd16384, POS_MAX, POS_MIN,
                        16'sd100, POS_MAX, POS_MIN));
    send_item(make_item(MODE_UNUSED, -16'sd1, -32'sd1, -32'sd1,
                        -16'sd1, -32'sd1, -32'sd1));

    // Random items under each idling and stall mix in turn.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      send_random(250);
    end

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the pipeline fills and in_stall rises.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = LONG_HOLD;
    send_random(40);
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    recv_stall_pct = 20;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rp2d_pkg.sv
src/rp2d_cordic.sv
src/rigid_pose_2d_transform.sv
tb/tb.sv
